>>> design/qf_pkg.sv
package qf_pkg;

  localparam int QuotientBitsDef  = 10;
  localparam int RemainderBitsDef = 16;

  // Moves of the walk pointer
  typedef enum logic [3:0] {
    P_HOLD = 4'd0,
    P_INC  = 4'd1,
    P_DEC  = 4'd2,
    P_FQ   = 4'd3,
    P_S    = 4'd4,
    P_SINC = 4'd5,
    P_BINC = 4'd6,
    P_POS  = 4'd7
  } ptr_op_e;

  // Slot table writes
  typedef enum logic [2:0] {
    W_NONE  = 3'd0,
    W_CLEAR = 3'd1,
    W_NEW   = 3'd2,
    W_SHIFT = 3'd3,
    W_POS   = 3'd4,
    W_OCC   = 3'd5
  } wr_op_e;

  typedef struct packed {
    ptr_op_e ptr_op;
    wr_op_e  wr_op;
    logic    latch;
    logic    save_s;
    logic    save_b;
    logic    save_pos;
    logic    pos_cont;
    logic    set_ovr;
    logic    cur_ld;
    logic    cnt_inc;
    logic    finish;
    logic    fin_present;
    logic    fin_status;
  } cmd_t;

  typedef struct packed {
    logic op_ins;
    logic occ;
    logic cont;
    logic shf;
    logic empty;
    logic match;
    logic p_is_fq;
    logic p_is_pos;
    logic pos_is_fq;
    logic p_last;
    logic full;
  } sts_t;

endpackage

>>> design/quotient_filter_insert_lookup_unit.sv
// Quotient filter with lookup and insert over 2^QUOTIENT_BITS slots held in one
// single-port-write, registered-read table. Pulse start_i while busy_o is low to
// issue a transaction; exactly one result comes back later on done_o for one
// cycle with present_o, status_o and element_count_o, and must be taken then:
// there is no way to stall it. The work for an item grows with the slots visited:
// the walk back to the cluster head, the walk forward over runs,
// the run scan or the search for a free slot, and for an insert one slot
// shifted right at a time, plus one or two final writes. The table gives one
// read per cycle, so cost follows cluster length. After reset busy_o stays
// high while the table is cleared.
module quotient_filter_insert_lookup_unit #(
  parameter int QUOTIENT_BITS  = qf_pkg::QuotientBitsDef,
  parameter int REMAINDER_BITS = qf_pkg::RemainderBitsDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  output logic                                    busy_o,
  input  logic                                    op_i,
  input  logic [QUOTIENT_BITS+REMAINDER_BITS-1:0] key_hash_i,
  output logic                                    done_o,
  output logic                                    present_o,
  output logic                                    status_o,
  output logic [QUOTIENT_BITS:0]                  element_count_o
);
  import qf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  qf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  qf_dp #(
    .QUOTIENT_BITS (QUOTIENT_BITS),
    .REMAINDER_BITS(REMAINDER_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (op_i),
    .key_hash_i     (key_hash_i),
    .sts_o          (sts),
    .done_o         (done_o),
    .present_o      (present_o),
    .status_o       (status_o),
    .element_count_o(element_count_o)
  );

endmodule

>>> design/qf_ctrl.sv
module qf_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  qf_pkg::sts_t sts_i,
  output qf_pkg::cmd_t cmd_o,
  output logic         busy_o
);
  import qf_pkg::*;

  typedef enum logic [12:0] {
    ST_CLEAR  = 13'b0000000000001,
    ST_IDLE   = 13'b0000000000010,
    ST_LOOK   = 13'b0000000000100,
    ST_BACK   = 13'b0000000001000,
    ST_SKIPC  = 13'b0000000010000,
    ST_SKIPO  = 13'b0000000100000,
    ST_FOUND  = 13'b0000001000000,
    ST_SCAN   = 13'b0000010000000,
    ST_APPEND = 13'b0000100000000,
    ST_FREE   = 13'b0001000000000,
    ST_SHIFT  = 13'b0010000000000,
    ST_WRPOS  = 13'b0100000000000,
    ST_FIXOCC = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   had_run_q, had_run_d;
  logic   first_q, first_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      had_run_q <= 1'b0;
      first_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      had_run_q <= had_run_d;
      first_q   <= first_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d   = state_q;
    had_run_d = had_run_q;
    first_d   = first_q;
    cmd_o     = '0;
    cmd_o.ptr_op = P_HOLD;
    cmd_o.wr_op  = W_NONE;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.wr_op  = W_CLEAR;
        cmd_o.ptr_op = P_INC;
        if (sts_i.p_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.latch  = 1'b1;
          cmd_o.ptr_op = P_FQ;
          state_d      = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!sts_i.op_ins) begin
          if (!sts_i.occ) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            state_d = ST_BACK;
          end
        end else if (sts_i.full) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = 1'b1;
          state_d          = ST_IDLE;
        end else if (sts_i.empty) begin
          cmd_o.wr_op       = W_NEW;
          cmd_o.cnt_inc     = 1'b1;
          cmd_o.finish      = 1'b1;
          cmd_o.fin_present = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          had_run_d     = sts_i.occ;
          cmd_o.set_ovr = 1'b1;
          state_d       = ST_BACK;
        end
      end
      ST_BACK: begin
        // walk back to the cluster head
        if (sts_i.shf) begin
          cmd_o.ptr_op = P_DEC;
        end else begin
          cmd_o.save_s = 1'b1;
          cmd_o.save_b = 1'b1;
          if (sts_i.p_is_fq) begin
            state_d = ST_FOUND;
          end else begin
            cmd_o.ptr_op = P_INC;
            state_d      = ST_SKIPC;
          end
        end
      end
      ST_SKIPC: begin
        if (sts_i.cont) begin
          cmd_o.ptr_op = P_INC;
        end else begin
          cmd_o.save_s = 1'b1;
          cmd_o.ptr_op = P_BINC;
          state_d      = ST_SKIPO;
        end
      end
      ST_SKIPO: begin
        if (!sts_i.occ) begin
          cmd_o.ptr_op = P_INC;
        end else begin
          cmd_o.save_b = 1'b1;
          if (sts_i.p_is_fq) begin
            cmd_o.ptr_op = P_S;
            state_d      = ST_FOUND;
          end else begin
            cmd_o.ptr_op = P_SINC;
            state_d      = ST_SKIPC;
          end
        end
      end
      ST_FOUND: begin
        if (!sts_i.op_ins) begin
          first_d = 1'b1;
          state_d = ST_SCAN;
        end else if (had_run_q) begin
          cmd_o.ptr_op = P_INC;
          state_d      = ST_APPEND;
        end else begin
          cmd_o.save_pos = 1'b1;
          state_d        = ST_FREE;
        end
      end
      ST_SCAN: begin
        if (!first_q && !sts_i.cont) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else if (sts_i.match) begin
          cmd_o.finish      = 1'b1;
          cmd_o.fin_present = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          first_d      = 1'b0;
          cmd_o.ptr_op = P_INC;
        end
      end
      ST_APPEND: begin
        if (sts_i.cont) begin
          cmd_o.ptr_op = P_INC;
        end else begin
          cmd_o.save_pos = 1'b1;
          cmd_o.pos_cont = 1'b1;
          state_d        = ST_FREE;
        end
      end
      ST_FREE: begin
        if (sts_i.empty) begin
          cmd_o.cur_ld = 1'b1;
          if (sts_i.p_is_pos) begin
            state_d = ST_WRPOS;
          end else begin
            cmd_o.ptr_op = P_DEC;
            state_d      = ST_SHIFT;
          end
        end else begin
          cmd_o.ptr_op = P_INC;
        end
      end
      ST_SHIFT: begin
        // move one slot right, walking back toward the insert point
        cmd_o.wr_op  = W_SHIFT;
        cmd_o.cur_ld = 1'b1;
        if (sts_i.p_is_pos) begin
          state_d = ST_WRPOS;
        end else begin
          cmd_o.ptr_op = P_DEC;
        end
      end
      ST_WRPOS: begin
        cmd_o.wr_op   = W_POS;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.pos_is_fq) begin
          cmd_o.finish      = 1'b1;
          cmd_o.fin_present = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          cmd_o.ptr_op = P_FQ;
          state_d      = ST_FIXOCC;
        end
      end
      ST_FIXOCC: begin
        cmd_o.wr_op       = W_OCC;
        cmd_o.finish      = 1'b1;
        cmd_o.fin_present = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/qf_dp.sv
module qf_dp #(
  parameter int QUOTIENT_BITS  = qf_pkg::QuotientBitsDef,
  parameter int REMAINDER_BITS = qf_pkg::RemainderBitsDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  qf_pkg::cmd_t                            cmd_i,
  input  logic                                    op_i,
  input  logic [QUOTIENT_BITS+REMAINDER_BITS-1:0] key_hash_i,
  output qf_pkg::sts_t                            sts_o,
  output logic                                    done_o,
  output logic                                    present_o,
  output logic                                    status_o,
  output logic [QUOTIENT_BITS:0]                  element_count_o
);
  import qf_pkg::*;

  localparam int QB     = QUOTIENT_BITS;
  localparam int RB     = REMAINDER_BITS;
  localparam int SW     = RB + 3;
  localparam int Slots  = 1 << QB;
  localparam int OccB   = RB + 2;
  localparam int ContB  = RB + 1;
  localparam int ShfB   = RB;

  logic [SW-1:0] mem_q [Slots];
  logic [SW-1:0] rdata_q, eff, cur_q, wdata;
  logic [QB-1:0] p_q, p_d, s_q, b_q, pos_q, fq_q, fq_d, waddr;
  logic [RB-1:0] fr_q;
  logic          op_q, ovr_q, cont_q, we;
  logic [QB:0]   count_q, count_d;

  assign fq_d = cmd_i.latch ? key_hash_i[QB+RB-1:RB] : fq_q;

  always_comb begin
    case (cmd_i.ptr_op)
      P_HOLD:  p_d = p_q;
      P_INC:   p_d = p_q + QB'(1);
      P_DEC:   p_d = p_q - QB'(1);
      P_FQ:    p_d = fq_d;
      P_S:     p_d = s_q;
      P_SINC:  p_d = s_q + QB'(1);
      P_BINC:  p_d = b_q + QB'(1);
      P_POS:   p_d = pos_q;
      default: p_d = p_q;
    endcase
  end

  // fq counts as occupied once an insert has claimed it
  always_comb begin
    eff       = rdata_q;
    eff[OccB] = rdata_q[OccB] | (ovr_q && (p_q == fq_q));
  end

  always_comb begin
    we    = 1'b1;
    waddr = p_q;
    wdata = '0;
    case (cmd_i.wr_op)
      W_NONE:  we = 1'b0;
      W_CLEAR: wdata = '0;
      W_NEW: begin
        waddr = fq_q;
        wdata = {1'b1, 1'b0, 1'b0, fr_q};
      end
      W_SHIFT: begin
        waddr = p_q + QB'(1);
        wdata = {cur_q[OccB], eff[ContB], 1'b1, eff[RB-1:0]};
      end
      W_POS: begin
        waddr = pos_q;
        wdata = {cur_q[OccB], cont_q, pos_q != fq_q, fr_q};
      end
      W_OCC: wdata = {1'b1, eff[ContB], eff[ShfB], eff[RB-1:0]};
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (we && (waddr == p_d)) rdata_q <= wdata;
    else rdata_q <= mem_q[p_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      fr_q <= key_hash_i[RB-1:0];
      op_q <= op_i;
    end
    fq_q <= fq_d;
    if (cmd_i.save_s) s_q <= p_q;
    if (cmd_i.save_b) b_q <= p_q;
    if (cmd_i.save_pos) begin
      pos_q  <= p_q;
      cont_q <= cmd_i.pos_cont;
    end
    if (cmd_i.cur_ld) cur_q <= eff;
  end

  assign count_d = cmd_i.cnt_inc ? count_q + (QB+1)'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q             <= '0;
      ovr_q           <= 1'b0;
      count_q         <= '0;
      done_o          <= 1'b0;
      present_o       <= 1'b0;
      status_o        <= 1'b0;
      element_count_o <= '0;
    end else begin
      p_q     <= p_d;
      count_q <= count_d;
      if (cmd_i.latch) ovr_q <= 1'b0;
      else if (cmd_i.set_ovr) ovr_q <= 1'b1;
      done_o <= cmd_i.finish;
      if (cmd_i.finish) begin
        present_o       <= cmd_i.fin_present;
        status_o        <= cmd_i.fin_status;
        element_count_o <= count_d;
      end
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.op_ins    = op_q;
    sts_o.occ       = eff[OccB];
    sts_o.cont      = eff[ContB];
    sts_o.shf       = eff[ShfB];
    sts_o.empty     = !eff[OccB] && !eff[ContB] && !eff[ShfB];
    sts_o.match     = (eff[RB-1:0] == fr_q);
    sts_o.p_is_fq   = (p_q == fq_q);
    sts_o.p_is_pos  = (p_q == pos_q);
    sts_o.pos_is_fq = (pos_q == fq_q);
    sts_o.p_last    = &p_q;
    sts_o.full      = count_q[QB];
  end

endmodule

>>> design/qf_checker.sv
module qf_checker #(
  parameter int QUOTIENT_BITS = qf_pkg::QuotientBitsDef
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start_i,
  input logic                   busy_o,
  input logic                   done_o,
  input logic                   present_o,
  input logic                   status_o,
  input logic [QUOTIENT_BITS:0] element_count_o
);

  // a result only closes a transaction that was in flight
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result without transaction");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted transaction not busy");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result repeated");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> $stable(element_count_o)) else $error("count moved without result");

  a_full_not_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> !present_o) else $error("refused insert reported stored");

endmodule

bind quotient_filter_insert_lookup_unit qf_checker #(
  .QUOTIENT_BITS(QUOTIENT_BITS)
) u_qf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .present_o      (present_o),
  .status_o       (status_o),
  .element_count_o(element_count_o)
);

>>> verif/qf_checker.sv
`timescale 1ns / 100ps

module qf_scoreboard #(
  parameter int   QB       = qf_pkg::QuotientBitsDef,
  parameter int   RB       = qf_pkg::RemainderBitsDef,
  parameter logic OpInsert = 1'b1,
  parameter logic StatOk   = 1'b0,
  parameter logic StatFull = 1'b1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic             op_i,
  input  logic [QB+RB-1:0] key_hash_i,
  input  logic             done_i,
  input  logic             present_i,
  input  logic             status_i,
  input  logic [QB:0]      element_count_i,
  output int               fail_count_o,
  output int               pending_o
);

  localparam int Slots = 1 << QB;

  typedef struct packed {
    logic        present;
    logic        status;
    logic [QB:0] count;
  } qf_result_t;

  logic [RB-1:0] rem_tbl [Slots];
  logic          occ_tbl [Slots];
  logic          cont_tbl[Slots];
  logic          shf_tbl [Slots];
  logic [QB:0]   stored;

  qf_result_t result_q[$];

  function automatic logic slot_free(logic [QB-1:0] i);
    return !occ_tbl[i] && !cont_tbl[i] && !shf_tbl[i];
  endfunction

  // Position where the run of canonical slot fq begins.
  function automatic logic [QB-1:0] run_begin(logic [QB-1:0] fq);
    logic [QB-1:0] h, b, s;
    int n, g;
    h = fq;
    n = 0;
    while (shf_tbl[h] && n < Slots) begin
      h = h - 1'b1;
      n++;
    end
    b = h;
    s = h;
    g = 0;
    while (b != fq && g < Slots) begin
      s = s + 1'b1;
      while (cont_tbl[s] && g < Slots) begin
        s = s + 1'b1;
        g++;
      end
      b = b + 1'b1;
      while (!occ_tbl[b] && g < Slots) begin
        b = b + 1'b1;
        g++;
      end
      g++;
    end
    return s;
  endfunction

  function automatic logic lookup_key(logic [QB-1:0] fq, logic [RB-1:0] fr);
    logic [QB-1:0] s;
    int n;
    if (!occ_tbl[fq]) return 1'b0;
    s = run_begin(fq);
    n = 0;
    do begin
      if (rem_tbl[s] == fr) return 1'b1;
      s = s + 1'b1;
      n++;
    end while (cont_tbl[s] && n < Slots);
    return 1'b0;
  endfunction

  function automatic logic insert_key(logic [QB-1:0] fq, logic [RB-1:0] fr);
    logic [QB-1:0] pos, f, i;
    logic had_run;
    int n;
    if (stored >= Slots) return 1'b0;
    if (slot_free(fq)) begin
      occ_tbl[fq]  = 1'b1;
      rem_tbl[fq]  = fr;
      cont_tbl[fq] = 1'b0;
      shf_tbl[fq]  = 1'b0;
      stored++;
      return 1'b1;
    end
    had_run = occ_tbl[fq];
    occ_tbl[fq] = 1'b1;
    pos = run_begin(fq);
    if (had_run) begin
      n = 0;
      do begin
        pos = pos + 1'b1;
        n++;
      end while (cont_tbl[pos] && n < Slots);
    end
    f = pos;
    n = 0;
    while (!slot_free(f) && n < Slots) begin
      f = f + 1'b1;
      n++;
    end
    if (n >= Slots) begin
      occ_tbl[fq] = had_run;
      return 1'b0;
    end
    i = f;
    while (i != pos) begin
      rem_tbl[i]  = rem_tbl[i - 1'b1];
      cont_tbl[i] = cont_tbl[i - 1'b1];
      shf_tbl[i]  = 1'b1;
      i = i - 1'b1;
    end
    rem_tbl[pos]  = fr;
    cont_tbl[pos] = had_run;
    shf_tbl[pos]  = (pos != fq);
    stored++;
    return 1'b1;
  endfunction

  initial begin
    for (int i = 0; i < Slots; i++) begin
      rem_tbl[i]  = '0;
      occ_tbl[i]  = 1'b0;
      cont_tbl[i] = 1'b0;
      shf_tbl[i]  = 1'b0;
    end
    stored = '0;
    fail_count_o = 0;
  end

  assign pending_o = result_q.size();

  always @(posedge clk_i) begin
    qf_result_t want, got;
    logic [QB-1:0] fq;
    logic [RB-1:0] fr;
    if (rst_ni) begin
      // Check the returning transaction before predicting a new one.
      if (done_i) begin
        got = '{present_i, status_i, element_count_i};
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, got);
          fail_count_o++;
        end else begin
          want = result_q.pop_front();
          if (want.present !== got.present) begin
            $display("%0t: present expected %0b actual %0b", $time,
                     want.present, got.present);
            fail_count_o++;
          end
          if (want.status !== got.status) begin
            $display("%0t: status expected %0b actual %0b", $time,
                     want.status, got.status);
            fail_count_o++;
          end
          if (want.count !== got.count) begin
            $display("%0t: element_count expected %0d actual %0d", $time,
                     want.count, got.count);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        fq = key_hash_i[QB+RB-1:RB];
        fr = key_hash_i[RB-1:0];
        if (op_i == OpInsert) begin
          want.present = insert_key(fq, fr);
          want.status  = want.present ? StatOk : StatFull;
        end else begin
          want.present = lookup_key(fq, fr);
          want.status  = StatOk;
        end
        want.count = stored;
        result_q.push_back(want);
      end
    end
  end

endmodule

>>> verif/tb_quotient_filter_insert_lookup_unit.sv
`timescale 1ns / 100ps

module tb_quotient_filter_insert_lookup_unit;

  localparam int   QB        = qf_pkg::QuotientBitsDef;
  localparam int   RB        = qf_pkg::RemainderBitsDef;
  localparam logic OpLookup  = 1'b0;
  localparam logic OpInsert  = 1'b1;
  localparam int   IdleLimit = 20000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             op_i = OpLookup;
  logic [QB+RB-1:0] key_hash_i = '0;
  logic             busy_o, done_o, present_o, status_o;
  logic [QB:0]      element_count_o;
  int               fail_count, pending;
  int               idle_cycles = 0;
  int               burst_left = 0;
  logic [QB+RB-1:0] stored_keys[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  quotient_filter_insert_lookup_unit dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .key_hash_i,
    .done_o, .present_o, .status_o, .element_count_o
  );

  qf_scoreboard #(.QB(QB), .RB(RB), .OpInsert(OpInsert)) qf_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .op_i, .key_hash_i,
    .done_i(done_o), .present_i(present_o), .status_i(status_o),
    .element_count_i(element_count_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: count cycles with no accepted transaction and no result.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic issue(logic op, logic [QB+RB-1:0] key);
    int gap;
    start_i    <= 1'b1;
    op_i       <= op;
    key_hash_i <= key;
    do @(posedge clk_i); while (busy_o);
    if (op == OpInsert) stored_keys.push_back(key);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic logic [QB+RB-1:0] mk_key(int q, int r);
    return {q[QB-1:0], r[RB-1:0]};
  endfunction

  initial begin
    int base;
    logic [QB+RB-1:0] k;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, extremes, duplicates, wrap-around, mid-cluster runs.
    issue(OpLookup, '0);
    issue(OpInsert, '0);
    issue(OpInsert, '1);
    issue(OpLookup, '0);
    issue(OpLookup, '1);
    issue(OpInsert, '0);
    issue(OpLookup, mk_key(0, 1));
    issue(OpInsert, mk_key(1023, 5));
    issue(OpInsert, mk_key(1023, 3));
    issue(OpInsert, mk_key(0, 7));
    issue(OpInsert, mk_key(1, 9));
    issue(OpLookup, mk_key(1023, 3));
    issue(OpLookup, mk_key(0, 7));
    issue(OpLookup, mk_key(1, 9));
    issue(OpInsert, mk_key(5, 100));
    issue(OpInsert, mk_key(5, 200));
    issue(OpInsert, mk_key(7, 300));
    issue(OpInsert, mk_key(6, 400));
    issue(OpLookup, mk_key(6, 400));
    issue(OpLookup, mk_key(7, 300));
    issue(OpLookup, mk_key(5, 201));
    issue(OpLookup, mk_key(4, 100));
    issue(OpLookup, mk_key(2, 0));

    // Random: mostly dense windows to build long clusters, some noise.
    for (int n = 0; n < 510; n++) begin
      if (n % 40 == 0) base = $urandom_range(0, (1 << QB) - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: issue(OpInsert, mk_key(base + $urandom_range(0, 15), $urandom));
        4, 5, 6: begin
          k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
          issue(OpLookup, k);
        end
        7: issue(OpLookup, mk_key(base + $urandom_range(0, 15), $urandom));
        8: issue(OpInsert, (QB+RB)'($urandom));
        default: issue(OpLookup, (QB+RB)'($urandom));
      endcase
    end

    // Close with hits on stored keys mixed with random probes.
    for (int n = 0; n < 8; n++) begin
      k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      issue(OpLookup, k);
      issue(OpLookup, (QB+RB)'($urandom));
    end

    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
design/qf_pkg.sv
design/qf_ctrl.sv
design/qf_dp.sv
design/quotient_filter_insert_lookup_unit.sv
design/qf_checker.sv
verif/qf_checker.sv
verif/tb_quotient_filter_insert_lookup_unit.sv
